### sv/spq_pkg.sv
// Shared types and constants for the stable priority queue.
package spq_pkg;

    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [PRIO_W-1:0] TOP_PRIORITY = 3'd5;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPRIO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } cell_t;

    typedef struct packed {
        logic load;
        logic commit;
    } ctl_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

endpackage

### sv/spq_if.sv
// Handshake channels for commands and results.
interface spq_req_if import spq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic signed [VALUE_W-1:0] item_value;
    logic [PRIO_W-1:0]         item_priority;

    modport source (output valid, command, item_value, item_priority, input ready);
    modport sink (input valid, command, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] popped_value;
    logic [PRIO_W-1:0]         popped_priority;
    logic [COUNT_W-1:0]        entry_count;

    modport source (output valid, status, popped_value, popped_priority, entry_count,
                    input ready);
    modport sink (input valid, status, popped_value, popped_priority, entry_count,
                  output ready);
endinterface

### sv/stable_priority_queue.sv
// Top level of the stable bounded priority queue.
//
//  channel    modport  payload                                              
//  request    sink     command, item_value, item_priority                   
//  response   source   status, popped_value, popped_priority, entry_count    
//
//  Each command passes an accept step (S_IDLE) and an execute step in the
//  cell row (S_EXEC); no new beat is taken until the last one has committed.
//  A push shifts every cell behind the insertion point in the same commit.
//  Reset clears the count and the handshake state; cell contents are not cleared.
//  A result beat waits in its output register; execute stalls while it is unread.
module stable_priority_queue import spq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    spq_req_if.sink   request,
    spq_rsp_if.source response
);

    ctl_cmd_t ctl;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (response.valid),
        .out_ready (response.ready),
        .ctl       (ctl)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .command         (request.command),
        .item_value      (request.item_value),
        .item_priority   (request.item_priority),
        .status          (response.status),
        .popped_value    (response.popped_value),
        .popped_priority (response.popped_priority),
        .entry_count     (response.entry_count)
    );

endmodule

### sv/spq_ctrl.sv
// Command sequencer: accepts one beat, executes it, holds the result beat.
module spq_ctrl import spq_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output ctl_cmd_t ctl
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready   = (state_reg == S_IDLE);
    assign ctl.load   = in_valid && in_ready;
    assign ctl.commit = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ctl.load)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (ctl.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_result_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("result beat dropped before it was taken");

    a_commit_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> (state_reg == S_EXEC))
        else $error("accepted beat not executed");

    a_no_load_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.load && ctl.commit))
        else $error("load and commit overlap");

endmodule

### sv/spq_datapath.sv
// Sorted row of compare-and-shift cells with command and result registers.
module spq_datapath import spq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctl_cmd_t                  ctl,
    input  logic                      command,
    input  logic signed [VALUE_W-1:0] item_value,
    input  logic [PRIO_W-1:0]         item_priority,
    output logic [STATUS_W-1:0]       status,
    output logic signed [VALUE_W-1:0] popped_value,
    output logic [PRIO_W-1:0]         popped_priority,
    output logic [COUNT_W-1:0]        entry_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    cell_t                     cells_reg [DEPTH];
    cell_t                     cells_next [DEPTH];
    logic [CW-1:0]             count_reg, count_next;
    logic                      cmd_reg;
    logic signed [VALUE_W-1:0] val_reg;
    logic [PRIO_W-1:0]         prio_reg;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic signed [VALUE_W-1:0] pval_reg, pval_next;
    logic [PRIO_W-1:0]         pprio_reg, pprio_next;
    logic [DEPTH-1:0]          gt;
    logic                      push_ok, pop_ok;
    cell_t                     new_cell;

    assign new_cell.value = val_reg;
    assign new_cell.prio  = prio_reg;

    assign push_ok = (cmd_reg == CMD_PUSH) && (prio_reg <= TOP_PRIORITY)
                     && (count_reg != FULL_COUNT);
    assign pop_ok  = (cmd_reg == CMD_POP) && (count_reg != '0);

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            assign gt[i] = (CW'(i) < count_reg) && (cells_reg[i].prio > prio_reg);

            if (i == 0)
            begin : g_head
                always_comb
                begin
                    cells_next[i] = cells_reg[i];
                    if (ctl.commit && push_ok)
                    begin
                        if (gt[i] || (CW'(i) == count_reg))
                        begin
                            cells_next[i] = new_cell;
                        end
                    end
                    else if (ctl.commit && pop_ok)
                    begin
                        cells_next[i] = cells_reg[i+1];
                    end
                end
            end
            else if (i == DEPTH - 1)
            begin : g_tail
                always_comb
                begin
                    cells_next[i] = cells_reg[i];
                    if (ctl.commit && push_ok)
                    begin
                        if (gt[i-1])
                        begin
                            cells_next[i] = cells_reg[i-1];
                        end
                        else if (gt[i] || (CW'(i) == count_reg))
                        begin
                            cells_next[i] = new_cell;
                        end
                    end
                end
            end
            else
            begin : g_mid
                always_comb
                begin
                    cells_next[i] = cells_reg[i];
                    if (ctl.commit && push_ok)
                    begin
                        if (gt[i-1])
                        begin
                            cells_next[i] = cells_reg[i-1];
                        end
                        else if (gt[i] || (CW'(i) == count_reg))
                        begin
                            cells_next[i] = new_cell;
                        end
                    end
                    else if (ctl.commit && pop_ok)
                    begin
                        cells_next[i] = cells_reg[i+1];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                cells_reg[i] <= cells_next[i];
            end
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        pval_next   = pval_reg;
        pprio_next  = pprio_reg;
        if (ctl.commit)
        begin
            pval_next  = '0;
            pprio_next = '0;
            if (cmd_reg == CMD_PUSH)
            begin
                if (prio_reg > TOP_PRIORITY)
                begin
                    status_next = ST_BADPRIO;
                end
                else if (count_reg == FULL_COUNT)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_OK;
                    count_next  = count_reg + 1'b1;
                end
            end
            else
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    status_next = ST_OK;
                    pval_next   = cells_reg[0].value;
                    pprio_next  = cells_reg[0].prio;
                    count_next  = count_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= command;
            val_reg  <= item_value;
            prio_reg <= item_priority;
        end
        status_reg <= status_next;
        pval_reg   <= pval_next;
        pprio_reg  <= pprio_next;
    end

    assign status          = status_reg;
    assign popped_value    = pval_reg;
    assign popped_priority = pprio_reg;
    assign entry_count     = COUNT_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit && push_ok |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not add one entry");

    a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit && pop_ok |=> pval_reg == $past(cells_reg[0].value))
        else $error("pop did not return the head entry");

    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit && !push_ok && !pop_ok |=> $stable(count_reg))
        else $error("rejected command changed the count");

endmodule
